// ===== src/tds_pkg.sv =====
// Package with the request and result types and action codes of the deadline selector.
package tds_pkg;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_ARM  = 2'd2;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_TICKS   = 2'd1;
    localparam logic [1:0] REG_BOOT    = 2'd2;
    localparam logic [1:0] REG_QUANTUM = 2'd3;

    localparam int unsigned DIV_STEPS = 64;

    typedef struct packed {
        logic [63:0] now_count;
        logic        cpu_idle;
        logic        wake_pending;
        logic [63:0] next_wake_ms;
    } t_tds_req;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] deadline_count;
    } t_tds_res;

endpackage

// ===== src/tickless_deadline_select.sv =====
// Top level of the tickless deadline selector: divider cell chain and arming pipeline.
// Pipeline from an accepted start to the o_done strobe: 64 division cells,
// one uptime compare stage, one multiply stage, one add stage, one select stage.
// Throughput: one transaction per cycle; o_busy stays low, the cell chain sets the depth.
// Reset: synchronous active-low i_rst_n clears all valid bits and loads the register
// defaults (mode off, rate 0, boot count 0, quantum 10 ms); results cannot be stalled.
module tickless_deadline_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  tds_pkg::t_tds_req i_req,
    output logic              o_done,
    output tds_pkg::t_tds_res o_res,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import tds_pkg::*;

    logic        r_mode;
    logic [31:0] r_ticks;
    logic [63:0] r_boot;
    logic [9:0]  r_quantum;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_ticks   <= 32'd0;
            r_boot    <= 64'd0;
            r_quantum <= 10'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[0];
                REG_TICKS:   r_ticks   <= i_cfg_data[31:0];
                REG_BOOT:    r_boot    <= i_cfg_data;
                REG_QUANTUM: r_quantum <= i_cfg_data[9:0];
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Division chain: uptime = (now - boot) / ticks, one quotient bit per cell.
    logic        w_v   [DIV_STEPS+1];
    t_tds_req    w_req [DIV_STEPS+1];
    logic [31:0] w_rem [DIV_STEPS+1];
    logic [63:0] w_dq  [DIV_STEPS+1];

    assign w_v[0]   = i_start;
    assign w_req[0] = i_req;
    assign w_rem[0] = 32'd0;
    assign w_dq[0]  = i_req.now_count - r_boot;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        tds_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .i_req   (w_req[g]),
            .i_rem   (w_rem[g]),
            .i_dq    (w_dq[g]),
            .i_div   (r_ticks),
            .o_valid (w_v[g+1]),
            .o_req   (w_req[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dq    (w_dq[g+1])
        );
    end

    // Stage 1: uptime, due test and remaining milliseconds.
    logic [63:0] w_up;
    logic        r1_v;
    t_tds_req    r1_req;
    logic        r1_due;
    logic [63:0] r1_left;

    assign w_up = (r_ticks == 32'd0) ? 64'd0 : w_dq[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        r1_req  <= w_req[DIV_STEPS];
        r1_due  <= (w_req[DIV_STEPS].next_wake_ms <= w_up);
        r1_left <= w_req[DIV_STEPS].next_wake_ms - w_up;
    end

    // Stage 2: partial products of the wake distance and the quantum product.
    logic        r2_v;
    t_tds_req    r2_req;
    logic        r2_due;
    logic [63:0] r2_plo;
    logic [31:0] r2_phi;
    logic [41:0] r2_qt;
    logic [63:0] w_phi;

    assign w_phi = r1_left[63:32] * r_ticks;

    always_ff @(posedge i_clk) begin
        r2_req <= r1_req;
        r2_due <= r1_due;
        r2_plo <= r1_left[31:0] * r_ticks;
        r2_phi <= w_phi[31:0];
        r2_qt  <= r_quantum * r_ticks;
    end

    // Stage 3: wake and quantum deadlines, wrapping modulo 2^64.
    logic        r3_v;
    t_tds_req    r3_req;
    logic        r3_due;
    logic [63:0] r3_wake_at;
    logic [63:0] r3_qend;

    always_ff @(posedge i_clk) begin
        r3_req     <= r2_req;
        r3_due     <= r2_due;
        r3_wake_at <= r2_req.now_count + r2_plo + {r2_phi, 32'd0};
        r3_qend    <= r2_req.now_count + {22'd0, r2_qt};
    end

    // Stage 4: action selection into the output register.
    t_tds_res n_res;
    t_tds_res r_res;
    logic     r_done;

    always_comb begin
        n_res.action         = ACT_ARM;
        n_res.deadline_count = 64'd0;
        if (!r_mode) begin
            n_res.action = ACT_NONE;
        end else if (r3_req.cpu_idle && !r3_req.wake_pending) begin
            n_res.action = ACT_STOP;
        end else if (!r3_req.wake_pending) begin
            n_res.deadline_count = r3_qend;
        end else if (r3_due) begin
            n_res.deadline_count = r3_req.now_count;
        end else if (r3_req.cpu_idle || (r3_wake_at < r3_qend)) begin
            n_res.deadline_count = r3_wake_at;
        end else begin
            n_res.deadline_count = r3_qend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Valid bits of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_v   <= w_v[DIV_STEPS];
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r_done <= r3_v;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== src/tds_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and passes the transaction on.
module tds_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tds_pkg::t_tds_req i_req,
    input  logic [31:0]       i_rem,
    input  logic [63:0]       i_dq,
    input  logic [31:0]       i_div,
    output logic              o_valid,
    output tds_pkg::t_tds_req o_req,
    output logic [31:0]       o_rem,
    output logic [63:0]       o_dq
);
    import tds_pkg::*;

    logic [32:0] w_sh;
    logic [32:0] w_sub;
    logic        w_ge;
    logic [31:0] n_rem;
    logic [63:0] n_dq;
    logic        r_valid;
    t_tds_req    r_req;
    logic [31:0] r_rem;
    logic [63:0] r_dq;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_sh  = {i_rem, i_dq[63]};
        w_sub = w_sh - {1'b0, i_div};
        w_ge  = (w_sh >= {1'b0, i_div});
        n_rem = w_ge ? w_sub[31:0] : w_sh[31:0];
        n_dq  = {i_dq[62:0], w_ge};
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
        r_rem <= n_rem;
        r_dq  <= n_dq;
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;

endmodule

// ===== src/tds_checker.sv =====
// Port-level checker for the deadline selector, bound to the top level.
module tds_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              o_busy,
    input  logic              o_done,
    input  tds_pkg::t_tds_res o_res
);
    import tds_pkg::*;

    // Every result traces back to an earlier accepted transaction.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 68))
        else $error("result without matching transaction");

    // Stop and no-action results carry a zero deadline.
    a_zero_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.action != ACT_ARM)) |-> (o_res.deadline_count == 64'd0))
        else $error("nonzero deadline on a non-arm result");

    // The action code is always a defined one.
    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.action == ACT_NONE || o_res.action == ACT_STOP ||
                    o_res.action == ACT_ARM))
        else $error("undefined action code");

endmodule

bind tickless_deadline_select tds_checker u_tds_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ===== tb/tds_checker.sv =====
// Checker for the deadline selector: mirrors its registers, predicts each result and compares.
`timescale 1ns / 100ps
module tds_scoreboard (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  tds_pkg::t_tds_req i_req,
    input  logic              i_done,
    input  tds_pkg::t_tds_res i_res,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import tds_pkg::*;

    logic        mode_on;
    logic [31:0] rate;
    logic [63:0] boot;
    logic [9:0]  slice_ms;
    t_tds_res    deadline_q[$];

    // Works out the timer action and deadline for one request.
    function automatic t_tds_res pick_deadline(t_tds_req rq);
        t_tds_res    r;
        logic [63:0] up;
        logic [63:0] slice_end;
        logic [63:0] wake_at;
        r.action = ACT_ARM;
        r.deadline_count = '0;
        if (!mode_on) begin
            r.action = ACT_NONE;
        end else if (rq.cpu_idle && !rq.wake_pending) begin
            r.action = ACT_STOP;
        end else begin
            slice_end = rq.now_count + 64'(slice_ms) * 64'(rate);
            if (rq.wake_pending) begin
                up = (rate == 0) ? 64'd0 : (rq.now_count - boot) / 64'(rate);
                if (rq.next_wake_ms <= up) begin
                    r.deadline_count = rq.now_count;
                end else begin
                    wake_at = rq.now_count + (rq.next_wake_ms - up) * 64'(rate);
                    r.deadline_count = (rq.cpu_idle || wake_at < slice_end) ?
                        wake_at : slice_end;
                end
            end else begin
                r.deadline_count = slice_end;
            end
        end
        return r;
    endfunction

    assign o_pending = deadline_q.size();

    // Register mirror, prediction on accepted requests, comparison on result strobes.
    always @(posedge i_clk) begin
        t_tds_res want;
        int       bad;
        bad = 0;
        if (!i_rst_n) begin
            mode_on  <= 1'b0;
            rate     <= '0;
            boot     <= '0;
            slice_ms <= 10'd10;
            o_errors <= 0;
            deadline_q.delete();
        end else begin
            if (i_done) begin
                if (deadline_q.size() == 0) begin
                    $error("unexpected result transaction: action %0d deadline %h",
                           i_res.action, i_res.deadline_count);
                    bad++;
                end else begin
                    want = deadline_q.pop_front();
                    if (want.action !== i_res.action) begin
                        $error("action: expected %0d actual %0d", want.action, i_res.action);
                        bad++;
                    end
                    if (want.deadline_count !== i_res.deadline_count) begin
                        $error("deadline_count: expected %h actual %h",
                               want.deadline_count, i_res.deadline_count);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
            if (i_start && !i_busy)
                deadline_q.push_back(pick_deadline(i_req));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:    mode_on  <= i_cfg_data[0];
                    REG_TICKS:   rate     <= i_cfg_data[31:0];
                    REG_BOOT:    boot     <= i_cfg_data;
                    REG_QUANTUM: slice_ms <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Testbench top for the deadline selector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import tds_pkg::*;

    localparam int LATENCY  = 68;
    localparam int IDLE_MAX = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_tds_req    req = '0;
    logic        done;
    t_tds_res    res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          calm;

    tickless_deadline_select i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy), .i_req(req),
        .o_done(done), .o_res(res), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    tds_scoreboard i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_req(req),
        .i_done(done), .i_res(res), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Watchdog: counts cycles with no accepted transaction on either side.
    always @(posedge clk) begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_MAX) begin
            $display("tickless_deadline_select verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Biased 64-bit value: extremes, small numbers or fully random.
    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 3000));
            default: return rand64();
        endcase
    endfunction

    // Sends one request; waits for acceptance and inserts sender gaps.
    task automatic send_req(input t_tds_req rq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= rq;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Holds the sender until every expected result has arrived, then lets the pipe drain.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // One register write, with the write enable dropped low again after it.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Request whose wake time mostly lands near the current uptime so every branch is hit.
    function automatic t_tds_req make_req(input logic [63:0] boot, input logic [31:0] rate);
        t_tds_req    rq;
        logic [63:0] up;
        rq.now_count    = ($urandom_range(0, 3) == 0) ? pick64()
                                                      : boot + 64'($urandom_range(0, 1 << 20));
        rq.cpu_idle     = 1'($urandom_range(0, 1));
        rq.wake_pending = $urandom_range(0, 3) != 0;
        up = (rate == 0) ? 64'd0 : (rq.now_count - boot) / 64'(rate);
        case ($urandom_range(0, 3))
            0: rq.next_wake_ms = pick64();
            1: rq.next_wake_ms = up - 64'($urandom_range(0, 3));
            default: rq.next_wake_ms = up + 64'($urandom_range(0, 1200));
        endcase
        return rq;
    endfunction

    initial begin
        t_tds_req    rq;
        logic [63:0] boot;
        logic [31:0] rate;
        logic [9:0]  slice;
        logic [63:0] spare;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults give mode off, then extreme requests.
        send_req('{now_count: '1, cpu_idle: 1'b1, wake_pending: 1'b1, next_wake_ms: '1});
        send_req('{now_count: '0, cpu_idle: 1'b0, wake_pending: 1'b0, next_wake_ms: '0});
        drain();
        write_reg(REG_MODE, 64'd1);
        // Uncalibrated rate: every arm lands at now.
        send_req('{now_count: 64'h1234, cpu_idle: 1'b0, wake_pending: 1'b1,
                   next_wake_ms: 64'd5});
        send_req('{now_count: '1, cpu_idle: 1'b1, wake_pending: 1'b0, next_wake_ms: '1});
        drain();
        write_reg(REG_TICKS, 64'hFFFF_FFFF);
        write_reg(REG_BOOT, '1);
        write_reg(REG_QUANTUM, 64'd0);
        send_req('{now_count: '1, cpu_idle: 1'b0, wake_pending: 1'b0, next_wake_ms: '0});
        send_req('{now_count: '0, cpu_idle: 1'b0, wake_pending: 1'b1, next_wake_ms: '1});
        send_req('{now_count: '0, cpu_idle: 1'b1, wake_pending: 1'b1, next_wake_ms: '1});
        send_req('{now_count: 64'd5, cpu_idle: 1'b1, wake_pending: 1'b1,
                   next_wake_ms: 64'd0});
        drain();
        write_reg(REG_TICKS, 64'd1000);
        write_reg(REG_BOOT, 64'd0);
        write_reg(REG_QUANTUM, 64'h3FF);
        send_req('{now_count: 64'd20000, cpu_idle: 1'b0, wake_pending: 1'b1,
                   next_wake_ms: 64'd25});
        send_req('{now_count: 64'd20000, cpu_idle: 1'b0, wake_pending: 1'b1,
                   next_wake_ms: 64'd2000});
        send_req('{now_count: 64'd20000, cpu_idle: 1'b1, wake_pending: 1'b1,
                   next_wake_ms: 64'd2000});
        send_req('{now_count: 64'd20000, cpu_idle: 1'b0, wake_pending: 1'b1,
                   next_wake_ms: 64'd20});
        drain();

        // Random phases with varying registers and sender idling.
        for (int ph = 0; ph < 17; ph++) begin
            case (ph % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 53;
                2: send_idle_pct = 22;
                default: send_idle_pct = $urandom_range(0, 80);
            endcase
            case ($urandom_range(0, 4))
                0: rate = '0;
                1: rate = '1;
                default: rate = $urandom_range(1, 5000);
            endcase
            boot  = pick64();
            slice = (ph % 5 == 0) ? 10'($urandom_range(0, 1023))
                                  : 10'($urandom_range(1, 1000));
            spare = rand64();
            write_reg(REG_MODE, (ph % 6 == 5) ? 64'd0 : {spare[63:1], 1'b1});
            spare = rand64();
            write_reg(REG_TICKS, {spare[63:32], rate});
            write_reg(REG_BOOT, boot);
            spare = rand64();
            write_reg(REG_QUANTUM, {spare[63:10], slice});
            calm = $urandom_range(0, 1);
            for (int n = 0; n < 50; n++) begin
                rq = make_req(boot, rate);
                send_req(rq);
            end
            drain();
        end

        start <= 1'b0;
        @(posedge clk);
        calm = 0;
        while (pending != 0 && calm < 10 * LATENCY) begin
            calm++;
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tickless_deadline_select verification clean");
        else
            $display("tickless_deadline_select verification failed");
        $finish;
    end
endmodule
